[src/depth_preferred_transposition_table_assert.svh]
// Assertion macros for the transposition table block.
`ifndef DEPTH_PREFERRED_TRANSPOSITION_TABLE_ASSERT_SVH
`define DEPTH_PREFERRED_TRANSPOSITION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DPTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transposition table check failed");

// Next-cycle implication, disabled during reset.
`define DPTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transposition table check failed");

`endif

[src/dptt_pkg.sv]
// Shared types and constants of the transposition table block.
package dptt_pkg;

   localparam int ENTRIES = 1024;
   localparam int IDX_W   = $clog2(ENTRIES);

   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 16;
   localparam int SCORE_W = 32;
   localparam int BOUND_W = 2;
   localparam int MOVE_W  = 16;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_PROBE = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DEPTH_W-1:0] depth;
      logic [SCORE_W-1:0] score;
      logic [BOUND_W-1:0] bound;
      logic [MOVE_W-1:0]  move;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             sweep_wr;
      logic [IDX_W-1:0] sweep_addr;
      logic             exec;
   } ctrl_type;

   typedef struct packed {
      cmd_type in_cmd;
      logic    rsp_free;
   } status_type;

endpackage

[src/depth_preferred_transposition_table.sv]
// Direct-mapped, depth-preferred transposition table with ENTRIES slots indexed by the
// low key bits (ENTRIES must be a power of two). A store or probe does one registered
// read of the slot memories, then, once the response register is free, the key/depth
// compare, the slot write and the load of the response register. A clear first runs the
// sweep that writes the valid memory one slot per cycle. After reset the same sweep runs
// with req_tready low. A new request is taken while a response still waits in the
// output register.
`include "depth_preferred_transposition_table_assert.svh"

module depth_preferred_transposition_table import dptt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key[63:0], search_depth[79:64], score[111:80], bound_kind[113:112],
   // best_move[129:114], zero fill[135:130]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit[0], hit_depth[16:1], hit_score[48:17], hit_bound[50:49], hit_move[66:51],
   // written[67], zero fill[71:68]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   ctrl_type   ctrl;
   status_type status;

   dptt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   dptt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctrl       (ctrl),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   `DPTT_ASSERT_NEXT(a_one_request_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `DPTT_ASSERT_NOW(a_exec_needs_free_rsp, clock, reset, ctrl.exec, status.rsp_free)
   `DPTT_ASSERT_NOW(a_hit_excludes_written, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[67]))
   `DPTT_ASSERT_NOW(a_sweep_after_reset, clock, reset, $fell(reset), !req_tready)

endmodule

[src/dptt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/dptt_ctrl.sv]
// Controller: sequences request capture, valid-bit sweeps and execution.
module dptt_ctrl import dptt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic             sweep_last;

   assign sweep_last = (sweep_cnt_ff == IDX_W'(ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      sweep_cnt_in    = sweep_cnt_ff;
      req_tready      = 1'b0;
      ctrl.capture    = 1'b0;
      ctrl.sweep_wr   = 1'b0;
      ctrl.sweep_addr = sweep_cnt_ff;
      ctrl.exec       = 1'b0;
      case (state_ff)
         ST_INIT, ST_SWEEP: begin
            ctrl.sweep_wr = 1'b1;
            sweep_cnt_in  = sweep_last ? '0 : sweep_cnt_ff + 1'b1;
            if (sweep_last) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_EXEC;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.capture = 1'b1;
               state_in     = (status.in_cmd == CMD_CLEAR) ? ST_SWEEP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take the response
            if (status.rsp_free) begin
               ctrl.exec = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

[src/dptt_datapath.sv]
// Datapath: request registers, slot memories, replacement compare and result register.
module dptt_datapath import dptt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  ctrl_type              ctrl,
   output status_type            status,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   entry_type             in_entry;
   entry_type             cap_ff;
   cmd_type               cap_cmd_ff;
   entry_type             slot_rd;
   logic                  slot_valid_rd;
   logic [IDX_W-1:0]      in_idx, cap_idx, rd_addr, wr_addr;
   logic                  hit, written;
   logic                  vld_wr_en, ent_wr_en;
   logic [RSP_DATA_W-1:0] rsp_data_in, rsp_data_ff;
   logic                  rsp_valid_ff;

   assign in_entry.key   = req_tdata[63:0];
   assign in_entry.depth = req_tdata[79:64];
   assign in_entry.score = req_tdata[111:80];
   assign in_entry.bound = req_tdata[113:112];
   assign in_entry.move  = req_tdata[129:114];

   assign in_idx  = in_entry.key[IDX_W-1:0];
   assign cap_idx = cap_ff.key[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cap_ff     <= in_entry;
         cap_cmd_ff <= cmd_type'(req_tuser);
      end
   end

   // read the slot at the incoming index so its data is ready in the next cycle
   assign rd_addr = ctrl.capture ? in_idx : cap_idx;

   assign hit     = (cap_cmd_ff == CMD_PROBE) && slot_valid_rd && (slot_rd.key == cap_ff.key);
   assign written = (cap_cmd_ff == CMD_STORE) &&
                    (!slot_valid_rd || ($signed(cap_ff.depth) >= $signed(slot_rd.depth)));

   assign ent_wr_en = ctrl.exec && written;
   assign vld_wr_en = ent_wr_en || ctrl.sweep_wr;
   assign wr_addr   = ctrl.sweep_wr ? ctrl.sweep_addr : cap_idx;

   dptt_ram #(
      .WIDTH (1),
      .DEPTH (ENTRIES)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_wr_en),
      .wr_addr (wr_addr),
      .wr_data (!ctrl.sweep_wr),
      .rd_addr (rd_addr),
      .rd_data (slot_valid_rd)
   );

   dptt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (cap_idx),
      .wr_data (cap_ff),
      .rd_addr (rd_addr),
      .rd_data (slot_rd)
   );

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = hit;
      rsp_data_in[67]    = written;
      if (hit) begin
         rsp_data_in[16:1]  = slot_rd.depth;
         rsp_data_in[48:17] = slot_rd.score;
         rsp_data_in[50:49] = slot_rd.bound;
         rsp_data_in[66:51] = slot_rd.move;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.in_cmd   = cmd_type'(req_tuser);
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/dptt_answer_check.sv]
`timescale 1ns / 1ps
// Response checker for the transposition table: mirrors the slots and compares every response.
module dptt_answer_check import dptt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // key[63:0], search_depth[79:64], score[111:80], bound_kind[113:112],
   // best_move[129:114], zero fill[135:130]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit[0], hit_depth[16:1], hit_score[48:17], hit_bound[50:49], hit_move[66:51],
   // written[67], zero fill[71:68]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    probe_hits,
   output int                    slot_writes,
   output int                    responses_seen
);

   localparam int DEPTH_LSB = KEY_W;
   localparam int SCORE_LSB = DEPTH_LSB + DEPTH_W;
   localparam int BOUND_LSB = SCORE_LSB + SCORE_W;
   localparam int MOVE_LSB  = BOUND_LSB + BOUND_W;

   // Last member sits in the lowest bits, matching the response layout.
   typedef struct packed {
      logic               written;
      logic [MOVE_W-1:0]  hit_move;
      logic [BOUND_W-1:0] hit_bound;
      logic [SCORE_W-1:0] hit_score;
      logic [DEPTH_W-1:0] hit_depth;
      logic               hit;
   } answer_type;

   logic                      line_valid [ENTRIES];
   logic [KEY_W-1:0]          line_key   [ENTRIES];
   logic signed [DEPTH_W-1:0] line_depth [ENTRIES];
   logic [SCORE_W-1:0]        line_score [ENTRIES];
   logic [BOUND_W-1:0]        line_bound [ENTRIES];
   logic [MOVE_W-1:0]         line_move  [ENTRIES];

   answer_type expected_answers [$];

   function automatic answer_type table_outcome(logic [1:0] op,
                                                logic [REQ_DATA_W-1:0] fields);
      answer_type                ans;
      logic [KEY_W-1:0]          key;
      logic signed [DEPTH_W-1:0] depth;
      logic [IDX_W-1:0]          slot;
      ans   = '0;
      key   = fields[KEY_W-1:0];
      depth = fields[DEPTH_LSB +: DEPTH_W];
      slot  = key[IDX_W-1:0];
      case (op)
         CMD_STORE: begin
            // Replace an empty slot, or one searched no deeper than this request.
            if (!line_valid[slot] || depth >= line_depth[slot]) begin
               line_valid[slot] = 1'b1;
               line_key[slot]   = key;
               line_depth[slot] = depth;
               line_score[slot] = fields[SCORE_LSB +: SCORE_W];
               line_bound[slot] = fields[BOUND_LSB +: BOUND_W];
               line_move[slot]  = fields[MOVE_LSB +: MOVE_W];
               ans.written      = 1'b1;
            end
         end
         CMD_PROBE: begin
            if (line_valid[slot] && line_key[slot] == key) begin
               ans.hit       = 1'b1;
               ans.hit_depth = line_depth[slot];
               ans.hit_score = line_score[slot];
               ans.hit_bound = line_bound[slot];
               ans.hit_move  = line_move[slot];
            end
         end
         CMD_CLEAR: begin
            foreach (line_valid[i]) line_valid[i] = 1'b0;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      answer_type seen;
      answer_type want;
      if (reset) begin
         foreach (line_valid[i]) line_valid[i] = 1'b0;
         expected_answers.delete();
         mismatches     = 0;
         probe_hits     = 0;
         slot_writes    = 0;
         responses_seen = 0;
      end else begin
         // A response always belongs to an earlier request, so check it first.
         if (rsp_tvalid && rsp_tready) begin
            seen = answer_type'(rsp_tdata[$bits(answer_type)-1:0]);
            responses_seen++;
            if (expected_answers.size() == 0) begin
               $error("response 0x%0h arrived with no request pending", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               check_field("hit", want.hit, seen.hit);
               check_field("hit_depth", want.hit_depth, seen.hit_depth);
               check_field("hit_score", want.hit_score, seen.hit_score);
               check_field("hit_bound", want.hit_bound, seen.hit_bound);
               check_field("hit_move", want.hit_move, seen.hit_move);
               check_field("written", want.written, seen.written);
            end
         end
         if (req_tvalid && req_tready) begin
            want = table_outcome(req_tuser, req_tdata);
            probe_hits  += want.hit;
            slot_writes += want.written;
            expected_answers.push_back(want);
         end
      end
      outstanding = expected_answers.size();
   end

endmodule

[tb/tb_depth_preferred_transposition_table.sv]
`timescale 1ns / 1ps
// Testbench top for the transposition table: request stimulus, response pacing and verdict.
module tb_depth_preferred_transposition_table;
   import dptt_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         POOL_SIZE   = 24;
   localparam int         HOLD_CYCLES = 400;
   localparam int         FIELD_BITS  = KEY_W + DEPTH_W + SCORE_W + BOUND_W + MOVE_W;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = 2'd0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatches;
   int outstanding;
   int probe_hits;
   int slot_writes;
   int responses_seen;

   bit quiet     = 1'b0;
   bit gaps_on   = 1'b1;
   bit long_hold = 1'b0;

   int sent_stores;
   int sent_probes;
   int sent_clears;
   int sent_unused;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   always #5 clock = ~clock;

   depth_preferred_transposition_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dptt_answer_check answer_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .probe_hits     (probe_hits),
      .slot_writes    (slot_writes),
      .responses_seen (responses_seen)
   );

   task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] key,
                               logic [DEPTH_W-1:0] depth, logic [SCORE_W-1:0] score,
                               logic [BOUND_W-1:0] bound, logic [MOVE_W-1:0] mv);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-FIELD_BITS){1'b0}}, mv, bound, score, depth, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         CMD_STORE: sent_stores++;
         CMD_PROBE: sent_probes++;
         CMD_CLEAR: sent_clears++;
         default:   sent_unused++;
      endcase
   endtask

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      int unsigned      pick;
      k    = {$urandom, $urandom};
      pick = $urandom_range(0, 15);
      // Crowd the keys onto a few slots at both ends of the table.
      k[IDX_W-1:0] = pick[0] ? IDX_W'(ENTRIES - 1 - pick) : IDX_W'(pick);
      return k;
   endfunction

   function automatic logic [DEPTH_W-1:0] pick_depth();
      int unsigned roll;
      logic [DEPTH_W-1:0] d;
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
         d = DEPTH_W'($urandom_range(0, 12));
         return d - DEPTH_W'(4);
      end else if (roll < 17) begin
         return DEPTH_W'($urandom);
      end
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'hFFFF;
         2:       return 16'h0000;
         default: return 16'h7FFF;
      endcase
   endfunction

   task automatic random_request();
      int unsigned      roll;
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
      roll = $urandom_range(0, 199);
      if (roll < 2)        op = CMD_CLEAR;
      else if (roll < 8)   op = CMD_UNUSED;
      else if (roll < 100) op = CMD_STORE;
      else                 op = CMD_PROBE;
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE-1)]
                                       : {$urandom, $urandom};
      send_request(op, key, pick_depth(), $urandom, BOUND_W'($urandom_range(0, 3)),
                   MOVE_W'($urandom));
   endtask

   task automatic maybe_idle();
      if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, POOL_SIZE-1)] = fresh_key();
         random_request();
         maybe_idle();
      end
   endtask

   task automatic directed_cases();
      logic [KEY_W-1:0] k_low;
      logic [KEY_W-1:0] k_alias;
      logic [KEY_W-1:0] k_top;
      k_low   = 64'h0;
      k_alias = 64'h400;
      k_top   = '1;
      send_request(CMD_PROBE, k_low, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_STORE, k_low, 16'h8000, 32'h8000_0000, 2'd0, 16'h0000);
      send_request(CMD_PROBE, k_low, 16'h0, 32'h0, 2'd0, 16'h0);
      // Equal depth still replaces.
      send_request(CMD_STORE, k_low, 16'h8000, 32'h7FFF_FFFF, 2'd1, 16'h0001);
      send_request(CMD_STORE, k_alias, 16'h0064, 32'hFFFF_FF9C, 2'd2, 16'h1234);
      send_request(CMD_PROBE, k_low, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_PROBE, k_alias, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_STORE, k_alias, 16'h0063, 32'h1, 2'd0, 16'h4321);
      send_request(CMD_PROBE, k_alias, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_STORE, k_top, 16'h7FFF, 32'h7FFF_FFFF, 2'd3, 16'hFFFF);
      send_request(CMD_PROBE, k_top, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_STORE, k_top, 16'h8000, 32'h0, 2'd0, 16'h0);
      send_request(CMD_STORE, k_top, 16'h7FFF, 32'hFFFF_FFFF, 2'd3, 16'h0000);
      send_request(CMD_UNUSED, k_top, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
      send_request(CMD_PROBE, k_top, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
      send_request(CMD_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF, 32'hAAAA_5555, 2'd2,
                   16'hAAAA);
      send_request(CMD_PROBE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_PROBE, 64'h5555_5555_5555_5555, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_CLEAR, 64'h5555_5555_5555_5555, 16'h5555, 32'h5555_AAAA, 2'd1,
                   16'h5555);
      send_request(CMD_PROBE, k_top, 16'h0, 32'h0, 2'd0, 16'h0);
      send_request(CMD_PROBE, k_alias, 16'h0, 32'h0, 2'd0, 16'h0);
      // Empty slot takes even the shallowest store.
      send_request(CMD_STORE, k_top, 16'h8000, 32'h0000_0001, 2'd1, 16'h00FF);
      send_request(CMD_PROBE, k_top, 16'h0, 32'h0, 2'd0, 16'h0);
   endtask

   // Response side: random stall bursts, one long hold on request, none at the end.
   initial begin
      int cycle_count;
      bit stalls_on;
      cycle_count = 0;
      stalls_on   = 1'b1;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 50 == 0) stalls_on = ($urandom_range(0, 3) != 0);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = fresh_key();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      directed_cases();
      run_random(600);

      // Hold the sender until the table has answered everything.
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);

      // Keep offering requests back to back while the response side is held off.
      long_hold = 1'b1;
      repeat (60) random_request();

      run_random(600);
      quiet = 1'b1;
      run_random(150);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (16) @(posedge clock);

      $display("Covered %0d requests: %0d stores, %0d probes, %0d clears, %0d unused codes.",
               sent_stores + sent_probes + sent_clears + sent_unused,
               sent_stores, sent_probes, sent_clears, sent_unused);
      $display("Compared %0d responses; %0d probes hit and %0d stores replaced a slot.",
               responses_seen, probe_hits, slot_writes);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/dptt_pkg.sv
src/dptt_ram.sv
src/dptt_ctrl.sv
src/dptt_datapath.sv
src/depth_preferred_transposition_table.sv
tb/dptt_answer_check.sv
tb/tb_depth_preferred_transposition_table.sv
